[sv/ddd_pkg.sv]
// ----------------------------------------------------------------------------
// ddd_pkg
// Types, constants and calendar helpers for the date difference block.
// ----------------------------------------------------------------------------
package ddd_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD_START,
        ST_MOD_END,
        ST_CHECK,
        ST_WALK,
        ST_DONE
    } state_t;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int COUNT_W = 22;
    localparam int ACC_W   = 25;
    localparam int R400_W  = 9;

    localparam logic [YEAR_W-1:0]  YEAR_CYCLE = 14'd400;
    localparam logic [R400_W-1:0]  R400_LAST  = 9'd399;
    localparam logic [MONTH_W-1:0] JANUARY    = 4'd1;
    localparam logic [MONTH_W-1:0] FEBRUARY   = 4'd2;
    localparam logic [MONTH_W-1:0] DECEMBER   = 4'd12;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = 22'h3FFFFF;

    // Year position within the 400-year cycle -> leap year.
    function automatic logic is_leap(input logic [R400_W-1:0] r400);
        is_leap = (r400[1:0] == 2'd0) && (r400 != 9'd100) && (r400 != 9'd200)
                  && (r400 != 9'd300);
    endfunction

    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] month,
                                                    input logic leap);
        case (month)
            4'd1:    month_days = 5'd31;
            4'd2:    month_days = leap ? 5'd29 : 5'd28;
            4'd3:    month_days = 5'd31;
            4'd4:    month_days = 5'd30;
            4'd5:    month_days = 5'd31;
            4'd6:    month_days = 5'd30;
            4'd7:    month_days = 5'd31;
            4'd8:    month_days = 5'd31;
            4'd9:    month_days = 5'd30;
            4'd10:   month_days = 5'd31;
            4'd11:   month_days = 5'd30;
            4'd12:   month_days = 5'd31;
            default: month_days = 5'd0;
        endcase
    endfunction

endpackage

[sv/date_difference_in_days.sv]
// ----------------------------------------------------------------------------
// date_difference_in_days
// Gregorian day count between a start and an end date.
// ----------------------------------------------------------------------------
// One input word gives one output word. Each year is first reduced to its
// place in the 400-year cycle by repeated subtraction, then both dates are
// checked, and the count is built by walking month by month from the start
// month to the end month with one shared adder, one cycle per month. The
// input side is ready only while the block is idle; a finished result waits
// in the output register and does not hold off the next input word.
// Impossible dates give invalid_date = 1 and day_count = 0.
module date_difference_in_days #(
    parameter int YEAR_MAX = 9999
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // start_day[4:0], start_month[8:5], start_year[22:9], end_day[27:23],
    // end_month[31:28], end_year[45:32], include_end_day[46], zero[47]
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // day_count[21:0], invalid_date[22], zero[23]
    output logic [23:0] m_tdata
);

    localparam logic [15:0] YEAR_LIMIT = 16'(YEAR_MAX);

    ddd_pkg::state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;

    logic [ddd_pkg::DAY_W-1:0]   sd_reg, ed_reg;
    logic [ddd_pkg::MONTH_W-1:0] sm_reg, em_reg, cm_reg, cm_next;
    logic [ddd_pkg::YEAR_W-1:0]  sy_reg, ey_reg, cy_reg, cy_next;
    logic                        inc_reg;
    logic [ddd_pkg::YEAR_W-1:0]  rem_reg, rem_next;
    logic [ddd_pkg::R400_W-1:0]  sr_reg, sr_next, er_reg, er_next, cr_reg, cr_next;
    logic [ddd_pkg::ACC_W-1:0]   acc_reg, acc_next;
    logic                        bad_reg, bad_next;
    logic [23:0]                 out_reg, out_next;

    logic                        load;
    logic                        s_ok, e_ok, start_first;
    logic [ddd_pkg::ACC_W-1:0]   addend, sum;
    logic [ddd_pkg::ACC_W-1:0]   total;
    logic [ddd_pkg::COUNT_W-1:0] count;

    function automatic logic date_ok(input logic [ddd_pkg::DAY_W-1:0] d,
                                     input logic [ddd_pkg::MONTH_W-1:0] m,
                                     input logic [ddd_pkg::YEAR_W-1:0] y,
                                     input logic [ddd_pkg::R400_W-1:0] r);
        date_ok = (y != '0) && (16'(y) <= YEAR_LIMIT) && (m != '0)
                  && (m <= ddd_pkg::DECEMBER) && (d != '0)
                  && (d <= ddd_pkg::month_days(m, ddd_pkg::is_leap(r)));
    endfunction

    function automatic logic [ddd_pkg::ACC_W-1:0] ACC_W_EXT(
        input logic [ddd_pkg::DAY_W-1:0] v);
        ACC_W_EXT = {{(ddd_pkg::ACC_W-ddd_pkg::DAY_W){1'b0}}, v};
    endfunction

    assign s_tready = (state_reg == ddd_pkg::ST_IDLE);
    assign load     = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    // shared adder
    assign addend = ACC_W_EXT(ddd_pkg::month_days(cm_reg, ddd_pkg::is_leap(cr_reg)));
    assign sum    = acc_reg + addend;

    assign s_ok        = date_ok(sd_reg, sm_reg, sy_reg, sr_reg);
    assign e_ok        = date_ok(ed_reg, em_reg, ey_reg, er_reg);
    assign start_first = {sy_reg, sm_reg, sd_reg} < {ey_reg, em_reg, ed_reg};
    assign total  = acc_reg + {{(ddd_pkg::ACC_W-1){1'b0}}, inc_reg};
    assign count  = (total > {3'b000, ddd_pkg::COUNT_MAX}) ? ddd_pkg::COUNT_MAX
                                                          : total[ddd_pkg::COUNT_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        rem_next       = rem_reg;
        sr_next        = sr_reg;
        er_next        = er_reg;
        cr_next        = cr_reg;
        cm_next        = cm_reg;
        cy_next        = cy_reg;
        acc_next       = acc_reg;
        bad_next       = bad_reg;
        out_next       = out_reg;
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ddd_pkg::ST_IDLE:
            begin
                if (load)
                begin
                    rem_next   = s_tdata[22:9];
                    state_next = ddd_pkg::ST_MOD_START;
                end
            end
            ddd_pkg::ST_MOD_START:
            begin
                if (rem_reg >= ddd_pkg::YEAR_CYCLE)
                begin
                    rem_next = rem_reg - ddd_pkg::YEAR_CYCLE;
                end
                else
                begin
                    sr_next    = rem_reg[ddd_pkg::R400_W-1:0];
                    rem_next   = ey_reg;
                    state_next = ddd_pkg::ST_MOD_END;
                end
            end
            ddd_pkg::ST_MOD_END:
            begin
                if (rem_reg >= ddd_pkg::YEAR_CYCLE)
                begin
                    rem_next = rem_reg - ddd_pkg::YEAR_CYCLE;
                end
                else
                begin
                    er_next    = rem_reg[ddd_pkg::R400_W-1:0];
                    state_next = ddd_pkg::ST_CHECK;
                end
            end
            ddd_pkg::ST_CHECK:
            begin
                cm_next    = sm_reg;
                cy_next    = sy_reg;
                cr_next    = sr_reg;
                bad_next   = !(s_ok && e_ok);
                acc_next   = '0;
                state_next = ddd_pkg::ST_DONE;
                if (s_ok && e_ok && start_first)
                begin
                    // days of the end month minus days already gone in start month
                    acc_next   = ACC_W_EXT(ed_reg) - ACC_W_EXT(sd_reg);
                    state_next = ddd_pkg::ST_WALK;
                end
            end
            ddd_pkg::ST_WALK:
            begin
                if ((cm_reg == em_reg) && (cy_reg == ey_reg))
                begin
                    state_next = ddd_pkg::ST_DONE;
                end
                else
                begin
                    acc_next = sum;
                    if (cm_reg == ddd_pkg::DECEMBER)
                    begin
                        cm_next = ddd_pkg::JANUARY;
                        cy_next = cy_reg + 1'b1;
                        cr_next = (cr_reg == ddd_pkg::R400_LAST) ? '0 : cr_reg + 1'b1;
                    end
                    else
                    begin
                        cm_next = cm_reg + 1'b1;
                    end
                end
            end
            ddd_pkg::ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_next       = bad_reg ? {1'b0, 1'b1, {ddd_pkg::COUNT_W{1'b0}}}
                                             : {1'b0, 1'b0, count};
                    state_next     = ddd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ddd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ddd_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sd_reg  <= s_tdata[4:0];
            sm_reg  <= s_tdata[8:5];
            sy_reg  <= s_tdata[22:9];
            ed_reg  <= s_tdata[27:23];
            em_reg  <= s_tdata[31:28];
            ey_reg  <= s_tdata[45:32];
            inc_reg <= s_tdata[46];
        end
        rem_reg <= rem_next;
        sr_reg  <= sr_next;
        er_reg  <= er_next;
        cr_reg  <= cr_next;
        cm_reg  <= cm_next;
        cy_reg  <= cy_next;
        acc_reg <= acc_next;
        bad_reg <= bad_next;
        out_reg <= out_next;
    end

endmodule
